[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the 1-Wire bus master.
// Depends on nothing; its user includes it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define OWBM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define OWBM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/owbm_pkg.sv]
// Package of the 1-Wire bus master: payload structs, command codes and
// configuration register indexes. Depends on nothing.
package owbm_pkg;

    // Slot timer width and default recovery after a standard bus reset.
    localparam int TIMER_W           = 14;
    localparam int RESET_RECOVERY_US = 1000;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERDRIVE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SCALE = 1'b1;

    // Command codes.
    localparam logic [2:0] FN_RESET      = 3'd0;
    localparam logic [2:0] FN_WRITE_BIT  = 3'd1;
    localparam logic [2:0] FN_READ_BIT   = 3'd2;
    localparam logic [2:0] FN_TRIPLET    = 3'd3;
    localparam logic [2:0] FN_WRITE_BYTE = 3'd4;
    localparam logic [2:0] FN_READ_BYTE  = 3'd5;

    // Triplet code when both the id and the complement read back as one.
    localparam logic [2:0] TRIPLET_ABORT = 3'b011;

    // One tick request as it arrives.
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] func;
        logic [7:0] cmd_data;
        logic       line_level;
    } t_in_item;

    // One tick result.
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic [2:0] result_code;
    } t_out_item;

    // Classified tick held in the queue between front and back.
    typedef struct packed {
        logic       start;
        logic [2:0] func;
        logic [7:0] cmd_data;
        logic       line_level;
    } t_tick;

    // Configuration as seen by the slot engine; scale is never zero.
    typedef struct packed {
        logic                  overdrive;
        logic [CFG_DATA_W-1:0] scale;
    } t_cfg;

endpackage

[hw/rtl/one_wire_bus_master.sv]
// 1-Wire bus master, top level: configuration registers, front queue and
// slot sequencer. Depends on owbm_pkg, owbm_front and owbm_back.
//
// Usage: every request on the input channel is one microsecond tick of the
// bus. It carries the sampled wire level and, when the master is idle, may
// start a command (bus reset, write bit, read bit, search triplet, write
// byte, read byte). Every request yields exactly one result on the output
// channel: open-drain drive, busy, a done pulse on the last tick of a
// command, and the read data or result code on that tick.
// Throughput is one request per clock cycle while results are taken; a request
// passes the two-entry request queue and then the result register of the
// sequencer on its way to a result.
// When the receiver stalls, the result register holds its value, the queue
// fills and the input ready drops once both entries are taken; no tick is
// dropped. Reset empties the queue and the result register, puts the
// sequencer in idle, and sets standard timing with a delay scale of one.
// Configuration writes take effect at once and are meant for idle periods.
module one_wire_bus_master #(
    parameter int RESET_RECOVERY_US = owbm_pkg::RESET_RECOVERY_US
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  owbm_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output owbm_pkg::t_out_item                  o_out_item,
    input  logic                                 i_cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                            r_overdrive;
    logic [owbm_pkg::CFG_DATA_W-1:0] r_delay_scale;

    owbm_pkg::t_cfg  cfg;
    owbm_pkg::t_tick tick;
    logic            tick_valid;
    logic            tick_pop;

    // Configuration registers; a zero scale is stored as one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overdrive   <= 1'b0;
            r_delay_scale <= owbm_pkg::CFG_DATA_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == owbm_pkg::CFG_OVERDRIVE) begin
                r_overdrive <= i_cfg_data[0];
            end else if (i_cfg_index == owbm_pkg::CFG_DELAY_SCALE) begin
                r_delay_scale <= (i_cfg_data == '0) ? owbm_pkg::CFG_DATA_W'(1) : i_cfg_data;
            end
        end
    end

    assign cfg.overdrive = r_overdrive;
    assign cfg.scale     = r_delay_scale;

    owbm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_tick_valid (tick_valid),
        .i_tick_pop   (tick_pop),
        .o_tick       (tick)
    );

    owbm_back #(
        .RESET_RECOVERY_US (RESET_RECOVERY_US)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tick_valid (tick_valid),
        .o_tick_pop   (tick_pop),
        .i_tick       (tick),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

[hw/rtl/owbm_front.sv]
// Front of the 1-Wire bus master: classifies each tick request and queues it.
// Depends on owbm_pkg.
module owbm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  owbm_pkg::t_in_item i_in_item,
    output logic              o_tick_valid,
    input  logic              i_tick_pop,
    output owbm_pkg::t_tick   o_tick
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    owbm_pkg::t_tick r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    owbm_pkg::t_tick entry;
    logic            push;
    logic            pop;

    // A command starts only when flagged and its code is a known one.
    always_comb begin
        entry.start      = i_in_item.cmd_valid && (i_in_item.func <= owbm_pkg::FN_READ_BYTE);
        entry.func       = i_in_item.func;
        entry.cmd_data   = i_in_item.cmd_data;
        entry.line_level = i_in_item.line_level;
    end

    assign o_in_ready   = (r_count < (PTR_W + 1)'(DEPTH));
    assign push         = i_in_valid && o_in_ready;
    assign pop          = i_tick_pop && (r_count != '0);
    assign o_tick_valid = (r_count != '0);
    assign o_tick       = r_queue[r_rd_ptr];

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= entry;
        end
    end

endmodule

[hw/rtl/owbm_back.sv]
// Back of the 1-Wire bus master: slot sequencer that runs one tick per
// request and registers the result. Depends on owbm_pkg.
module owbm_back #(
    parameter int RESET_RECOVERY_US = owbm_pkg::RESET_RECOVERY_US
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  owbm_pkg::t_cfg      i_cfg,
    input  logic                i_tick_valid,
    output logic                o_tick_pop,
    input  owbm_pkg::t_tick     i_tick,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output owbm_pkg::t_out_item o_out_item
);

    localparam int TW = owbm_pkg::TIMER_W;
    localparam int SW = owbm_pkg::CFG_DATA_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOW,
        PH_WAIT,
        PH_SAMP,
        PH_REC
    } t_phase;

    typedef enum logic [1:0] {
        K_RESET,
        K_W0,
        K_W1,
        K_READ
    } t_kind;

    // Slot type of the next slot for the current command and bit.
    function automatic t_kind slot_kind(input logic [2:0] fn, input logic [7:0] sh,
                                        input logic [2:0] bc, input logic [2:0] tr);
        t_kind k;
        case (fn)
            owbm_pkg::FN_RESET: begin
                k = K_RESET;
            end
            owbm_pkg::FN_WRITE_BIT: begin
                k = sh[0] ? K_W1 : K_W0;
            end
            owbm_pkg::FN_TRIPLET: begin
                if (bc < 3'd2) begin
                    k = K_READ;
                end else begin
                    k = tr[2] ? K_READ : K_W0;
                end
            end
            owbm_pkg::FN_WRITE_BYTE: begin
                k = sh[0] ? K_READ : K_W0;
            end
            default: begin
                k = K_READ;
            end
        endcase
        return k;
    endfunction

    // Length of the low phase; the overdrive short low is a single tick.
    function automatic logic [TW-1:0] low_len(input t_kind k, input logic od,
                                              input logic [SW-1:0] s);
        logic [TW-1:0] base;
        logic [TW-1:0] len;
        case (k)
            K_RESET: begin
                base = od ? TW'(48) : TW'(480);
            end
            K_W0: begin
                base = od ? TW'(8) : TW'(60);
            end
            default: begin
                base = TW'(6);
            end
        endcase
        if (od && (k == K_W1 || k == K_READ)) begin
            len = TW'(1);
        end else begin
            len = base * TW'(s);
        end
        return len;
    endfunction

    // Length of the presence wait phase; only a bus reset has one.
    function automatic logic [TW-1:0] wait_len(input t_kind k, input logic od,
                                               input logic [SW-1:0] s);
        logic [TW-1:0] len;
        if (k == K_RESET) begin
            len = (od ? TW'(7) : TW'(70)) * TW'(s);
        end else begin
            len = '0;
        end
        return len;
    endfunction

    // Length of the release phase, sample tick included.
    function automatic logic [TW-1:0] rel_len(input t_kind k, input logic od,
                                              input logic [SW-1:0] s);
        logic [TW-1:0] base;
        logic [TW-1:0] len;
        case (k)
            K_RESET: begin
                base = TW'(40);
            end
            K_W0: begin
                base = od ? TW'(5) : TW'(10);
            end
            K_W1: begin
                base = od ? TW'(10) : TW'(64);
            end
            default: begin
                base = od ? TW'(8) : TW'(55);
            end
        endcase
        if (k == K_RESET && !od) begin
            len = TW'(RESET_RECOVERY_US);
        end else begin
            len = base * TW'(s);
        end
        return len;
    endfunction

    t_phase              r_phase;
    logic [TW-1:0]       r_timer;
    logic [2:0]          r_bit_count;
    logic [7:0]          r_shift;
    logic [2:0]          r_func;
    logic [2:0]          r_triplet;
    logic                r_out_valid;
    owbm_pkg::t_out_item r_out_item;

    t_phase              n_phase;
    logic [TW-1:0]       n_timer;
    logic [2:0]          n_bit_count;
    logic [7:0]          n_shift;
    logic [2:0]          n_func;
    logic [2:0]          n_triplet;
    owbm_pkg::t_out_item n_out_item;

    logic          pop;
    logic          active;
    logic          slot_end;
    logic          fin;
    logic [TW-1:0] span;
    t_kind         kind;

    assign pop         = i_tick_valid && (!r_out_valid || i_out_ready);
    assign o_tick_pop  = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // One tick of the slot sequencer.
    always_comb begin
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_func      = r_func;
        n_triplet   = r_triplet;
        n_out_item  = '0;
        active      = 1'b1;
        slot_end    = 1'b0;
        fin         = 1'b0;
        span        = '0;
        kind        = K_READ;

        // Idle: a valid command starts its first slot on this very tick.
        if (r_phase == PH_IDLE) begin
            if (i_tick.start) begin
                n_func      = i_tick.func;
                n_shift     = i_tick.cmd_data;
                n_bit_count = '0;
                n_triplet   = '0;
                n_phase     = PH_LOW;
                n_timer     = low_len(slot_kind(n_func, n_shift, n_bit_count, n_triplet),
                                      i_cfg.overdrive, i_cfg.scale);
            end else begin
                active = 1'b0;
            end
        end

        if (active) begin
            n_out_item.busy_res = 1'b1;
            kind = slot_kind(n_func, n_shift, n_bit_count, n_triplet);

            // Phase timing.
            case (n_phase)
                PH_LOW: begin
                    n_out_item.drive_low = 1'b1;
                    if (n_timer <= TW'(1)) begin
                        span = wait_len(kind, i_cfg.overdrive, i_cfg.scale);
                        if (span != '0) begin
                            n_phase = PH_WAIT;
                            n_timer = span;
                        end else begin
                            n_phase = PH_SAMP;
                            n_timer = '0;
                        end
                    end else begin
                        n_timer = n_timer - 1'b1;
                    end
                end
                PH_WAIT: begin
                    if (n_timer <= TW'(1)) begin
                        n_phase = PH_SAMP;
                        n_timer = '0;
                    end else begin
                        n_timer = n_timer - 1'b1;
                    end
                end
                PH_SAMP: begin
                    span = rel_len(kind, i_cfg.overdrive, i_cfg.scale);
                    // Sample the bus on the first release tick.
                    case (n_func)
                        owbm_pkg::FN_RESET, owbm_pkg::FN_READ_BIT: begin
                            n_shift = {7'd0, i_tick.line_level};
                        end
                        owbm_pkg::FN_TRIPLET: begin
                            if (n_bit_count == 3'd0) begin
                                n_triplet = {2'd0, i_tick.line_level};
                            end else if (n_bit_count == 3'd1) begin
                                n_triplet = n_triplet | {1'b0, i_tick.line_level, 1'b0};
                            end
                        end
                        owbm_pkg::FN_READ_BYTE: begin
                            n_shift = {i_tick.line_level, n_shift[7:1]};
                        end
                        default: begin
                        end
                    endcase
                    if (span <= TW'(1)) begin
                        slot_end = 1'b1;
                    end else begin
                        n_phase = PH_REC;
                        n_timer = span - 1'b1;
                    end
                end
                PH_REC: begin
                    if (n_timer <= TW'(1)) begin
                        slot_end = 1'b1;
                    end else begin
                        n_timer = n_timer - 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // End of a slot: finish the command or start its next slot.
            if (slot_end) begin
                case (n_func)
                    owbm_pkg::FN_RESET: begin
                        n_out_item.result_code = {2'd0, n_shift[0]};
                        fin = 1'b1;
                    end
                    owbm_pkg::FN_WRITE_BIT: begin
                        fin = 1'b1;
                    end
                    owbm_pkg::FN_READ_BIT: begin
                        n_out_item.read_data = {7'd0, n_shift[0]};
                        fin = 1'b1;
                    end
                    owbm_pkg::FN_TRIPLET: begin
                        if (n_bit_count == 3'd0) begin
                            n_bit_count = 3'd1;
                            n_phase     = PH_LOW;
                            n_timer     = low_len(slot_kind(n_func, n_shift, n_bit_count,
                                                            n_triplet),
                                                  i_cfg.overdrive, i_cfg.scale);
                        end else if (n_bit_count == 3'd1) begin
                            if (n_triplet[0] && n_triplet[1]) begin
                                // No device answered either way: abort.
                                n_out_item.result_code = owbm_pkg::TRIPLET_ABORT;
                                fin = 1'b1;
                            end else begin
                                if (!n_triplet[0] && !n_triplet[1]) begin
                                    n_triplet = n_shift[0] ? 3'b100 : 3'b000;
                                end else begin
                                    n_triplet = n_triplet[0] ? 3'b101 : 3'b010;
                                end
                                n_bit_count = 3'd2;
                                n_phase     = PH_LOW;
                                n_timer     = low_len(slot_kind(n_func, n_shift, n_bit_count,
                                                                n_triplet),
                                                      i_cfg.overdrive, i_cfg.scale);
                            end
                        end else begin
                            n_out_item.result_code = n_triplet;
                            fin = 1'b1;
                        end
                    end
                    owbm_pkg::FN_WRITE_BYTE: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        if (n_bit_count == 3'd7) begin
                            fin = 1'b1;
                        end else begin
                            n_bit_count = n_bit_count + 1'b1;
                            n_phase     = PH_LOW;
                            n_timer     = low_len(slot_kind(n_func, n_shift, n_bit_count,
                                                            n_triplet),
                                                  i_cfg.overdrive, i_cfg.scale);
                        end
                    end
                    default: begin
                        if (n_bit_count == 3'd7) begin
                            n_out_item.read_data = n_shift;
                            fin = 1'b1;
                        end else begin
                            n_bit_count = n_bit_count + 1'b1;
                            n_phase     = PH_LOW;
                            n_timer     = low_len(slot_kind(n_func, n_shift, n_bit_count,
                                                            n_triplet),
                                                  i_cfg.overdrive, i_cfg.scale);
                        end
                    end
                endcase
            end

            if (fin) begin
                n_out_item.done_res = 1'b1;
                n_phase = PH_IDLE;
                n_timer = '0;
            end
        end
    end

    // Sequencer state and output register; both advance on each taken tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_func      <= '0;
            r_triplet   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase     <= n_phase;
                r_timer     <= n_timer;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_func      <= n_func;
                r_triplet   <= n_triplet;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

[hw/rtl/owbm_checker.sv]
// Port-level checker of the 1-Wire bus master, bound to the top level.
// Depends on owbm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module owbm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input owbm_pkg::t_out_item i_out_item
);

    // Set while the last delivered result showed a command still running.
    logic r_mid_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_cmd <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_mid_cmd <= i_out_item.busy_res && !i_out_item.done_res;
        end
    end

    // A stalled result stays put.
    `OWBM_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_item)), "stalled result changed")

    // Reset leaves an empty queue and no pending result.
    `OWBM_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (i_in_ready && !i_out_valid), "not empty after reset")

    // A command in progress ends only with a done pulse.
    `OWBM_ASSERT(a_busy_until_done, i_clk, i_rst_n, (i_out_valid && r_mid_cmd) |-> i_out_item.busy_res, "command ended without done")

    // Done and bus drive only happen inside a command.
    `OWBM_ASSERT(a_done_drive_busy, i_clk, i_rst_n, (i_out_valid && (i_out_item.done_res || i_out_item.drive_low)) |-> i_out_item.busy_res, "done or drive while idle")

    // Read data and code are zero away from the done tick.
    `OWBM_ASSERT(a_data_on_done, i_clk, i_rst_n, (i_out_valid && !i_out_item.done_res) |-> ((i_out_item.read_data == 8'd0) && (i_out_item.result_code == 3'd0)), "data outside done")

endmodule

bind one_wire_bus_master owbm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);
